@@ rtl/rlpf_pkg.sv @@
// Shared types, constants and field widths for the rate-limited position follower.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.
package rlpf_pkg;

    localparam int DEF_NUM_SLIDES          = 64;
    localparam int DEF_SUBSTEPS            = 10;
    localparam int DEF_IMPULSE_TABLE_DEPTH = 256;

    localparam int TGT_W  = 6;
    localparam int FT_W   = 16;
    localparam int POS_W  = 24;
    localparam int VEL_W  = 22;

    localparam int GAIN_W  = 16;
    localparam int VLIM_W  = 21;
    localparam int ALIM_W  = 16;
    localparam int AGAIN_W = 15;
    localparam int CFG_W   = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST        = 16'd20480;
    localparam logic [VLIM_W-1:0]  SPEED_LIMIT_RST   = 21'd983040;
    localparam logic [ALIM_W-1:0]  ACCEL_LIMIT_RST   = 16'd10240;
    localparam logic [AGAIN_W-1:0] APPROACH_GAIN_RST = 15'd4096;

    localparam int FRAME_MAX = 2185;
    localparam int FTC_W     = 12;
    localparam int DT_W      = 20;
    localparam int DT_SHIFT  = 25;
    localparam int AMAX_W    = 20;
    localparam int AMAX_SHIFT = 16;

    localparam int ERR_W    = 26;
    localparam int PV_W     = 30;
    localparam int PV_SHIFT = 12;
    localparam int NB_W     = 20;
    localparam int BOOST_SHIFT = 12;
    localparam int VSUM_W   = 31;
    localparam int VWIN_W   = 23;
    localparam int STEP_W   = 18;
    localparam int POS_SHIFT = 24;

    localparam int IMPULSE_SPAN = 8;
    localparam int SPAN_SHIFT   = $clog2(IMPULSE_SPAN) + 16;
    localparam int IMP_W        = 17;
    localparam longint EXP_E_Q24     = 45605202;
    localparam longint EXP_INV_E_Q24 = 6171993;

    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P,
        CFG_SPEED_LIMIT,
        CFG_ACCEL_LIMIT,
        CFG_APPROACH_GAIN
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_AMAX,
        ST_ERR,
        ST_IDX,
        ST_PV,
        ST_BOOST,
        ST_VEL,
        ST_ACC,
        ST_MPOS,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DT,
        MUL_AMAX,
        MUL_IDX,
        MUL_PV,
        MUL_BOOST,
        MUL_POS
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     ld_item;
        logic     ld_dt;
        logic     ld_amax;
        logic     ld_err;
        logic     ld_vwin;
        logic     ld_imp;
        logic     ld_pv;
        logic     ld_v;
        logic     ld_vel;
        logic     ld_pos;
        logic     ld_out;
    } t_ctrl;

endpackage

@@ rtl/rlpf_in_if.sv @@
// Input channel of the follower: one frame tick per item.
// Depends on rlpf_pkg for the field widths.
interface rlpf_in_if;
    logic                           valid;
    logic                           ready;
    logic [rlpf_pkg::TGT_W-1:0]     target_index;
    logic [rlpf_pkg::FT_W-1:0]      frame_time;

    modport source (output valid, output target_index, output frame_time, input ready);
    modport sink   (input valid, input target_index, input frame_time, output ready);
endinterface

@@ rtl/rlpf_out_if.sv @@
// Output channel of the follower: position and velocity after each frame.
// Depends on rlpf_pkg for the field widths.
interface rlpf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rlpf_pkg::POS_W-1:0]  position;
    logic signed [rlpf_pkg::VEL_W-1:0]  velocity;

    modport source (output valid, output position, output velocity, input ready);
    modport sink   (input valid, input position, input velocity, output ready);
endinterface

@@ rtl/rlpf_imp_rom.sv @@
// Impulse table 2x*exp(1-2x) in Q.16 over |e| in [0, span), registered read.
// Contents are fixed at elaboration; depends on rlpf_pkg.
module rlpf_imp_rom #(
    parameter int IMPULSE_TABLE_DEPTH = rlpf_pkg::DEF_IMPULSE_TABLE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rd_en,
    input  logic [$clog2(IMPULSE_TABLE_DEPTH)-1:0] i_addr,
    output logic [rlpf_pkg::IMP_W-1:0]             o_data
);

    function automatic longint f_div(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'sd1);
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    function automatic logic [rlpf_pkg::IMP_W-1:0] f_imp(input int k);
        longint x;
        longint t;
        longint m;
        longint f;
        longint sum;
        longint term;
        longint p;
        x = f_div(longint'(k) << rlpf_pkg::SPAN_SHIFT, longint'(IMPULSE_TABLE_DEPTH));
        t = 64'sd65536 - 2 * x;
        m = t >>> 16;
        f = t & 64'sd65535;
        sum = 0;
        term = 64'sd1 << 32;
        for (int n = 1; n <= 14; n++) begin
            sum = sum + term;
            term = f_div((term * f) >> 16, longint'(n));
        end
        for (int j = 0; j < 16; j++) begin
            if (m > 0) begin
                sum = (sum * rlpf_pkg::EXP_E_Q24) >> 24;
                m = m - 1;
            end else if (m < 0) begin
                sum = (sum * rlpf_pkg::EXP_INV_E_Q24) >> 24;
                m = m + 1;
            end
        end
        p = (2 * x * sum + (64'sd1 <<< 31)) >> 32;
        return rlpf_pkg::IMP_W'(p);
    endfunction

    logic [rlpf_pkg::IMP_W-1:0] rom_w [IMPULSE_TABLE_DEPTH];
    logic [rlpf_pkg::IMP_W-1:0] r_data;

    for (genvar g = 0; g < IMPULSE_TABLE_DEPTH; g++) begin : g_entry
        localparam logic [rlpf_pkg::IMP_W-1:0] ENTRY = f_imp(g);
        assign rom_w[g] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= rom_w[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

@@ rtl/rlpf_seq.sv @@
// Sequencer: steps the shared multiplier datapath through each sub-step.
// Handles both channel handshakes; depends on rlpf_pkg.
module rlpf_seq #(
    parameter int SUBSTEPS = rlpf_pkg::DEF_SUBSTEPS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rlpf_pkg::t_ctrl o_ctrl
);

    localparam int CNT_W = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUBSTEPS - 1);

    rlpf_pkg::t_state r_state;
    rlpf_pkg::t_state n_state;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] n_step;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             last_step;
    logic             out_free;

    assign last_step = (r_step == LAST_STEP);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rlpf_pkg::ST_IDLE:  if (i_in_valid) n_state = rlpf_pkg::ST_DT;
            rlpf_pkg::ST_DT:    n_state = rlpf_pkg::ST_AMAX;
            rlpf_pkg::ST_AMAX:  n_state = rlpf_pkg::ST_ERR;
            rlpf_pkg::ST_ERR:   n_state = rlpf_pkg::ST_IDX;
            rlpf_pkg::ST_IDX:   n_state = rlpf_pkg::ST_PV;
            rlpf_pkg::ST_PV:    n_state = rlpf_pkg::ST_BOOST;
            rlpf_pkg::ST_BOOST: n_state = rlpf_pkg::ST_VEL;
            rlpf_pkg::ST_VEL:   n_state = rlpf_pkg::ST_ACC;
            rlpf_pkg::ST_ACC:   n_state = rlpf_pkg::ST_MPOS;
            rlpf_pkg::ST_MPOS:  n_state = rlpf_pkg::ST_UPD;
            rlpf_pkg::ST_UPD: begin
                n_state = last_step ? rlpf_pkg::ST_DONE : rlpf_pkg::ST_ERR;
            end
            rlpf_pkg::ST_DONE:  if (out_free) n_state = rlpf_pkg::ST_IDLE;
            default:            n_state = rlpf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rlpf_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.ld_item = i_in_valid;
            end
            rlpf_pkg::ST_DT: begin
                o_ctrl.mul_sel = rlpf_pkg::MUL_DT;
            end
            rlpf_pkg::ST_AMAX: begin
                o_ctrl.ld_dt   = 1'b1;
                o_ctrl.mul_sel = rlpf_pkg::MUL_AMAX;
            end
            rlpf_pkg::ST_ERR: begin
                o_ctrl.ld_err  = 1'b1;
                o_ctrl.ld_amax = (r_step == '0);
            end
            rlpf_pkg::ST_IDX: begin
                o_ctrl.ld_vwin = 1'b1;
                o_ctrl.mul_sel = rlpf_pkg::MUL_IDX;
            end
            rlpf_pkg::ST_PV: begin
                o_ctrl.ld_imp  = 1'b1;
                o_ctrl.mul_sel = rlpf_pkg::MUL_PV;
            end
            rlpf_pkg::ST_BOOST: begin
                o_ctrl.ld_pv   = 1'b1;
                o_ctrl.mul_sel = rlpf_pkg::MUL_BOOST;
            end
            rlpf_pkg::ST_VEL: begin
                o_ctrl.ld_v = 1'b1;
            end
            rlpf_pkg::ST_ACC: begin
                o_ctrl.ld_vel = 1'b1;
            end
            rlpf_pkg::ST_MPOS: begin
                o_ctrl.mul_sel = rlpf_pkg::MUL_POS;
            end
            rlpf_pkg::ST_UPD: begin
                o_ctrl.ld_pos = 1'b1;
            end
            rlpf_pkg::ST_DONE: begin
                o_ctrl.ld_out = out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (o_ctrl.ld_item) begin
            n_step = '0;
        end else if (o_ctrl.ld_pos && !last_step) begin
            n_step = r_step + 1'b1;
        end
        n_out_valid = r_out_valid;
        if (o_ctrl.ld_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlpf_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/rlpf_dp.sv @@
// Datapath: configuration registers, follower state and one shared 27x27 multiplier.
// Driven by rlpf_seq through rlpf_pkg::t_ctrl; reads the table in rlpf_imp_rom.
module rlpf_dp #(
    parameter int NUM_SLIDES          = rlpf_pkg::DEF_NUM_SLIDES,
    parameter int SUBSTEPS            = rlpf_pkg::DEF_SUBSTEPS,
    parameter int IMPULSE_TABLE_DEPTH = rlpf_pkg::DEF_IMPULSE_TABLE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rlpf_pkg::t_ctrl                        i_ctrl,
    input  logic                                   i_cfg_we,
    input  logic [rlpf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [rlpf_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic [rlpf_pkg::TGT_W-1:0]             i_target_index,
    input  logic [rlpf_pkg::FT_W-1:0]              i_frame_time,
    output logic [$clog2(IMPULSE_TABLE_DEPTH)-1:0] o_rom_addr,
    input  logic [rlpf_pkg::IMP_W-1:0]             i_rom_data,
    output logic signed [rlpf_pkg::POS_W-1:0]      o_position,
    output logic signed [rlpf_pkg::VEL_W-1:0]      o_velocity
);

    localparam int IDX_W = $clog2(IMPULSE_TABLE_DEPTH);
    localparam int MUL_W = rlpf_pkg::MUL_W;
    localparam int PROD_W = rlpf_pkg::PROD_W;
    localparam int ERR_W = rlpf_pkg::ERR_W;
    localparam int POS_W = rlpf_pkg::POS_W;
    localparam int VEL_W = rlpf_pkg::VEL_W;
    localparam int VSUM_W = rlpf_pkg::VSUM_W;
    localparam int VWIN_W = rlpf_pkg::VWIN_W;
    localparam longint DT_RECIP =
        ((64'sd1 <<< rlpf_pkg::DT_SHIFT) + SUBSTEPS - 1) / SUBSTEPS;
    localparam logic [8:0] LAST_SLIDE = 9'(NUM_SLIDES - 1);

    logic [rlpf_pkg::GAIN_W-1:0]  r_gain_p;
    logic [rlpf_pkg::VLIM_W-1:0]  r_speed_limit;
    logic [rlpf_pkg::ALIM_W-1:0]  r_accel_limit;
    logic [rlpf_pkg::AGAIN_W-1:0] r_approach_gain;

    logic [rlpf_pkg::TGT_W-1:0]   r_tgt;
    logic [rlpf_pkg::FTC_W-1:0]   r_ft;
    logic [rlpf_pkg::DT_W-1:0]    r_dt;
    logic [rlpf_pkg::AMAX_W-1:0]  r_amax;
    logic signed [ERR_W-1:0]      r_err;
    logic [ERR_W-1:0]             r_abs;
    logic signed [VWIN_W-1:0]     r_vhi;
    logic signed [VWIN_W-1:0]     r_vlo;
    logic [VEL_W-1:0]             r_vabs;
    logic signed [rlpf_pkg::PV_W-1:0] r_pv;
    logic signed [VEL_W-1:0]      r_v;
    logic signed [VEL_W-1:0]      r_vel;
    logic signed [POS_W-1:0]      r_pos;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [POS_W-1:0]      r_out_pos;
    logic signed [VEL_W-1:0]      r_out_vel;

    logic signed [MUL_W-1:0]      op_a;
    logic signed [MUL_W-1:0]      op_b;
    logic signed [PROD_W-1:0]     n_prod;
    logic                         in_span;
    logic [rlpf_pkg::DT_W-1:0]    prod_dt;

    logic [rlpf_pkg::TGT_W-1:0]   n_tgt;
    logic [rlpf_pkg::FTC_W-1:0]   n_ft;
    logic signed [ERR_W-1:0]      n_err;
    logic signed [ERR_W-1:0]      n_nerr;
    logic signed [ERR_W-1:0]      pos_ext;
    logic signed [ERR_W-1:0]      tgt_ext;
    logic signed [VWIN_W-1:0]     vel_ext;
    logic signed [VWIN_W-1:0]     amax_ext;
    logic [VEL_W-1:0]             n_vabs;

    logic signed [VSUM_W-1:0]     pv_ext;
    logic signed [VSUM_W-1:0]     nb_ext;
    logic signed [VSUM_W-1:0]     vsum;
    logic signed [VSUM_W-1:0]     vlim;
    logic signed [VSUM_W-1:0]     vlim_n;
    logic signed [VEL_W-1:0]      n_v;

    logic [VEL_W-1:0]             v_abs;
    logic signed [VWIN_W-1:0]     v_ext;
    logic signed [VEL_W-1:0]      n_vel;

    logic signed [rlpf_pkg::STEP_W-1:0] pos_step;
    logic signed [POS_W:0]        pos_sum;
    logic signed [POS_W-1:0]      n_pos;

    assign prod_dt = r_prod[rlpf_pkg::DT_SHIFT +: rlpf_pkg::DT_W];
    assign in_span = (r_abs[ERR_W-1:rlpf_pkg::SPAN_SHIFT] == '0);

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_ctrl.mul_sel)
            rlpf_pkg::MUL_DT: begin
                op_a = MUL_W'({r_ft, 8'd0});
                op_b = MUL_W'(DT_RECIP);
            end
            rlpf_pkg::MUL_AMAX: begin
                op_a = MUL_W'(r_accel_limit);
                op_b = MUL_W'(prod_dt);
            end
            rlpf_pkg::MUL_IDX: begin
                op_a = MUL_W'(r_abs[rlpf_pkg::SPAN_SHIFT-1:0]);
                op_b = MUL_W'(IMPULSE_TABLE_DEPTH);
            end
            rlpf_pkg::MUL_PV: begin
                op_a = MUL_W'(r_err);
                op_b = MUL_W'(r_gain_p);
            end
            rlpf_pkg::MUL_BOOST: begin
                op_a = in_span ? MUL_W'(i_rom_data) : '0;
                op_b = MUL_W'(r_approach_gain);
            end
            rlpf_pkg::MUL_POS: begin
                op_a = MUL_W'(r_vel);
                op_b = MUL_W'(r_dt);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign n_prod = PROD_W'(op_a) * PROD_W'(op_b);
    assign o_rom_addr = r_prod[rlpf_pkg::SPAN_SHIFT +: IDX_W];

    always_comb begin
        n_tgt = ({3'd0, i_target_index} > LAST_SLIDE) ?
                rlpf_pkg::TGT_W'(LAST_SLIDE) : i_target_index;
        n_ft  = (i_frame_time > rlpf_pkg::FT_W'(rlpf_pkg::FRAME_MAX)) ?
                rlpf_pkg::FTC_W'(rlpf_pkg::FRAME_MAX) : i_frame_time[rlpf_pkg::FTC_W-1:0];
    end

    always_comb begin
        tgt_ext = $signed({{(ERR_W - rlpf_pkg::TGT_W - 16){1'b0}}, r_tgt, 16'd0});
        pos_ext = ERR_W'(r_pos);
        n_err   = tgt_ext - pos_ext;
        n_nerr  = pos_ext - tgt_ext;
        vel_ext = VWIN_W'(r_vel);
        amax_ext = $signed(VWIN_W'(r_amax));
        n_vabs  = r_vel[VEL_W-1] ? VEL_W'(-r_vel) : VEL_W'(r_vel);
    end

    always_comb begin
        pv_ext = VSUM_W'(r_pv);
        nb_ext = $signed(VSUM_W'(r_prod[rlpf_pkg::BOOST_SHIFT +: rlpf_pkg::NB_W]));
        vsum   = r_pv[rlpf_pkg::PV_W-1] ? (pv_ext - nb_ext) : (pv_ext + nb_ext);
        vlim   = $signed(VSUM_W'(r_speed_limit));
        vlim_n = -vlim;
        if (vsum > vlim) begin
            n_v = VEL_W'(vlim);
        end else if (vsum < vlim_n) begin
            n_v = VEL_W'(vlim_n);
        end else begin
            n_v = VEL_W'(vsum);
        end
    end

    always_comb begin
        v_abs = r_v[VEL_W-1] ? VEL_W'(-r_v) : VEL_W'(r_v);
        v_ext = VWIN_W'(r_v);
        n_vel = r_v;
        if (r_vabs < v_abs) begin
            if (v_ext > r_vhi) begin
                n_vel = VEL_W'(r_vhi);
            end else if (v_ext < r_vlo) begin
                n_vel = VEL_W'(r_vlo);
            end
        end
    end

    always_comb begin
        pos_step = r_prod[rlpf_pkg::POS_SHIFT +: rlpf_pkg::STEP_W];
        pos_sum  = (POS_W + 1)'(r_pos) + (POS_W + 1)'(pos_step);
        if (pos_sum > (POS_W + 1)'(rlpf_pkg::POS_MAX)) begin
            n_pos = rlpf_pkg::POS_MAX;
        end else if (pos_sum < (POS_W + 1)'(rlpf_pkg::POS_MIN)) begin
            n_pos = rlpf_pkg::POS_MIN;
        end else begin
            n_pos = POS_W'(pos_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p        <= rlpf_pkg::GAIN_P_RST;
            r_speed_limit   <= rlpf_pkg::SPEED_LIMIT_RST;
            r_accel_limit   <= rlpf_pkg::ACCEL_LIMIT_RST;
            r_approach_gain <= rlpf_pkg::APPROACH_GAIN_RST;
            r_pos           <= '0;
            r_vel           <= '0;
        end else begin
            if (i_cfg_we) begin
                case (rlpf_pkg::t_cfg_idx'(i_cfg_idx))
                    rlpf_pkg::CFG_GAIN_P:
                        r_gain_p <= i_cfg_data[rlpf_pkg::GAIN_W-1:0];
                    rlpf_pkg::CFG_SPEED_LIMIT:
                        r_speed_limit <= i_cfg_data[rlpf_pkg::VLIM_W-1:0];
                    rlpf_pkg::CFG_ACCEL_LIMIT:
                        r_accel_limit <= i_cfg_data[rlpf_pkg::ALIM_W-1:0];
                    rlpf_pkg::CFG_APPROACH_GAIN:
                        r_approach_gain <= i_cfg_data[rlpf_pkg::AGAIN_W-1:0];
                    default: begin
                        r_gain_p <= r_gain_p;
                    end
                endcase
            end
            if (i_ctrl.ld_vel) begin
                r_vel <= n_vel;
            end
            if (i_ctrl.ld_pos) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_ctrl.ld_item) begin
            r_tgt <= n_tgt;
            r_ft  <= n_ft;
        end
        if (i_ctrl.ld_dt) begin
            r_dt <= prod_dt;
        end
        if (i_ctrl.ld_amax) begin
            r_amax <= r_prod[rlpf_pkg::AMAX_SHIFT +: rlpf_pkg::AMAX_W];
        end
        if (i_ctrl.ld_err) begin
            r_err <= n_err;
            r_abs <= n_err[ERR_W-1] ? n_nerr : n_err;
        end
        if (i_ctrl.ld_vwin) begin
            r_vhi  <= vel_ext + amax_ext;
            r_vlo  <= vel_ext - amax_ext;
            r_vabs <= n_vabs;
        end
        if (i_ctrl.ld_pv) begin
            r_pv <= r_prod[rlpf_pkg::PV_SHIFT +: rlpf_pkg::PV_W];
        end
        if (i_ctrl.ld_v) begin
            r_v <= n_v;
        end
        if (i_ctrl.ld_out) begin
            r_out_pos <= r_pos;
            r_out_vel <= r_vel;
        end
    end

    assign o_position = r_out_pos;
    assign o_velocity = r_out_vel;

endmodule

@@ rtl/rate_limited_position_follower.sv @@
// Rate-limited position follower: P control with impulse boost, speed clamp and accel limit.
// Each item runs through ST_DT and ST_AMAX, then per sub-step through ERR, IDX, PV, BOOST, VEL,
// ACC, MPOS and UPD, with IDX, PV, BOOST and MPOS on the shared multiplier; an item is taken
// only after the last result has been loaded into the output register, where it waits while
// the next item is taken. Synchronous reset zeroes position and velocity and loads defaults.
module rate_limited_position_follower #(
    parameter int NUM_SLIDES          = rlpf_pkg::DEF_NUM_SLIDES,
    parameter int SUBSTEPS            = rlpf_pkg::DEF_SUBSTEPS,
    parameter int IMPULSE_TABLE_DEPTH = rlpf_pkg::DEF_IMPULSE_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rlpf_in_if.sink                        i_in,
    rlpf_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [rlpf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rlpf_pkg::CFG_W-1:0]     i_cfg_data
);

    rlpf_pkg::t_ctrl                         ctrl;
    logic [$clog2(IMPULSE_TABLE_DEPTH)-1:0]  rom_addr;
    logic [rlpf_pkg::IMP_W-1:0]              rom_data;
    logic                                    in_ready;
    logic                                    out_valid;
    logic signed [rlpf_pkg::POS_W-1:0]       position;
    logic signed [rlpf_pkg::VEL_W-1:0]       velocity;

    rlpf_seq #(
        .SUBSTEPS (SUBSTEPS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_ctrl      (ctrl)
    );

    rlpf_dp #(
        .NUM_SLIDES          (NUM_SLIDES),
        .SUBSTEPS            (SUBSTEPS),
        .IMPULSE_TABLE_DEPTH (IMPULSE_TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_target_index (i_in.target_index),
        .i_frame_time   (i_in.frame_time),
        .o_rom_addr     (rom_addr),
        .i_rom_data     (rom_data),
        .o_position     (position),
        .o_velocity     (velocity)
    );

    rlpf_imp_rom #(
        .IMPULSE_TABLE_DEPTH (IMPULSE_TABLE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (ctrl.ld_imp),
        .i_addr  (rom_addr),
        .o_data  (rom_data)
    );

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.position = position;
    assign o_out.velocity = velocity;

endmodule

@@ bench/rate_limited_position_follower_tb.sv @@
// Self-checking bench for rate_limited_position_follower: random frame ticks under changing limits.
// A fixed-point predictor in a small class tracks position and velocity and checks each result.
// Depends on rlpf_pkg and the rlpf_in_if / rlpf_out_if channel interfaces.
module rate_limited_position_follower_tb;
    import rlpf_pkg::*;

    localparam int NUM_SLIDES = DEF_NUM_SLIDES;
    localparam int SUBSTEPS   = DEF_SUBSTEPS;
    localparam int ROM_DEPTH  = DEF_IMPULSE_TABLE_DEPTH;

    localparam int unsigned GAIN_P_TOP   = 40960;
    localparam int unsigned SPEED_TOP    = 1966080;
    localparam int unsigned ACCEL_TOP    = 51200;
    localparam int unsigned APPROACH_TOP = 20480;

    typedef struct {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
    } follower_state_t;

    class follower_tracker;
        longint impulse_rom [ROM_DEPTH];
        longint pos_q16;
        longint vel_q16;
        longint gain_p;
        longint speed_limit;
        longint accel_limit;
        longint approach_gain;
        follower_state_t expected_states [$];
        int mismatch_count;

        function new();
            longint unsigned x;
            longint unsigned ex;
            for (int k = 0; k < ROM_DEPTH; k++) begin
                x = longint'(k) * (longint'(IMPULSE_SPAN) << 16) / ROM_DEPTH;
                ex = exp_q32(64'sd65536 - 2 * longint'(x));
                impulse_rom[k] = longint'((2 * x * ex + (64'd1 << 31)) >> 32);
            end
            pos_q16 = 0;
            vel_q16 = 0;
            gain_p = GAIN_P_RST;
            speed_limit = SPEED_LIMIT_RST;
            accel_limit = ACCEL_LIMIT_RST;
            approach_gain = APPROACH_GAIN_RST;
            mismatch_count = 0;
        endfunction

        // exp(t) for t in Q.16, result in Q.32, by series on the fraction and e^m on the rest
        function longint unsigned exp_q32(longint t);
            longint m;
            longint unsigned f;
            longint unsigned sum;
            longint unsigned term;
            m = t >>> 16;
            f = longint'(t - m * 65536);
            sum = 0;
            term = 64'd1 << 32;
            for (int k = 1; k <= 14; k++) begin
                sum += term;
                term = ((term * f) >> 16) / longint'(k);
            end
            while (m > 0) begin
                sum = (sum * EXP_E_Q24) >> 24;
                m--;
            end
            while (m < 0) begin
                sum = (sum * EXP_INV_E_Q24) >> 24;
                m++;
            end
            return sum;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_GAIN_P:        gain_p = value[GAIN_W-1:0];
                CFG_SPEED_LIMIT:   speed_limit = value[VLIM_W-1:0];
                CFG_ACCEL_LIMIT:   accel_limit = value[ALIM_W-1:0];
                CFG_APPROACH_GAIN: approach_gain = value[AGAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_frame(logic [TGT_W-1:0] tgt_in, logic [FT_W-1:0] ft_in);
            longint tgt, ft, dt, amax, err, abs_err, p_term, idx, imp, boost, v, a, cur;
            follower_state_t r;
            tgt = tgt_in;
            if (tgt > NUM_SLIDES - 1) tgt = NUM_SLIDES - 1;
            ft = ft_in;
            if (ft > FRAME_MAX) ft = FRAME_MAX;
            dt = (ft << 8) / SUBSTEPS;
            amax = (accel_limit * dt) >>> 16;
            for (int s = 0; s < SUBSTEPS; s++) begin
                err = (tgt << 16) - pos_q16;
                abs_err = err < 0 ? -err : err;
                p_term = (err * gain_p) >>> 12;
                idx = abs_err * ROM_DEPTH / (longint'(IMPULSE_SPAN) << 16);
                imp = idx < ROM_DEPTH ? impulse_rom[idx] : 0;
                boost = (imp * approach_gain) >>> 12;
                if (p_term < 0) boost = -boost;
                v = p_term + boost;
                if (v > speed_limit) v = speed_limit;
                if (v < -speed_limit) v = -speed_limit;
                cur = vel_q16 < 0 ? -vel_q16 : vel_q16;
                if (cur < (v < 0 ? -v : v)) begin
                    a = v - vel_q16;
                    if (a > amax) a = amax;
                    if (a < -amax) a = -amax;
                    v = vel_q16 + a;
                end
                vel_q16 = v;
                pos_q16 += (v * dt) >>> 24;
                if (pos_q16 > longint'(POS_MAX)) pos_q16 = POS_MAX;
                if (pos_q16 < longint'(POS_MIN)) pos_q16 = POS_MIN;
            end
            r.position = pos_q16[POS_W-1:0];
            r.velocity = vel_q16[VEL_W-1:0];
            expected_states.push_back(r);
        endfunction

        function void check_state(logic signed [POS_W-1:0] pos, logic signed [VEL_W-1:0] vel);
            follower_state_t r;
            if (expected_states.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: position %0d velocity %0d", pos, vel);
                return;
            end
            r = expected_states.pop_front();
            if (pos !== r.position || vel !== r.velocity) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: position exp %0d got %0d, velocity exp %0d got %0d",
                             r.position, pos, r.velocity, vel);
            end
        endfunction

        function int pending();
            return expected_states.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    bit                   calm = 1'b0;
    int                   stall_left = 0;
    follower_tracker      tracker;

    rlpf_in_if  in_if();
    rlpf_out_if out_if();

    rate_limited_position_follower #(
        .NUM_SLIDES(NUM_SLIDES),
        .SUBSTEPS(SUBSTEPS),
        .IMPULSE_TABLE_DEPTH(ROM_DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_if),
        .o_out(out_if),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            tracker.check_state(out_if.position, out_if.velocity);
    end

    function automatic logic [CFG_W-1:0] pick_setting(int unsigned stated_high, int width);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_W'(stated_high);
            2:       return CFG_W'((64'd1 << width) - 1);
            default: return CFG_W'($urandom_range(0, stated_high));
        endcase
    endfunction

    task automatic apply_limits(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] speed,
                                input logic [CFG_W-1:0] accel, input logic [CFG_W-1:0] boost);
        logic [CFG_W-1:0] vals [4];
        vals = '{gain, speed, accel, boost};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_cfg_idx'(r);
            i_cfg_data <= vals[r];
            tracker.write_reg(t_cfg_idx'(r), vals[r]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input logic [TGT_W-1:0] tgt, input logic [FT_W-1:0] ft);
        if (!calm) begin
            while ($urandom_range(0, 3) == 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b1;
        in_if.target_index <= tgt;
        in_if.frame_time <= ft;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.note_frame(tgt, ft);
    endtask

    task automatic run_frames(input logic [TGT_W-1:0] tgt, input logic [FT_W-1:0] ft, int count);
        for (int n = 0; n < count; n++)
            send_frame(tgt, ft);
    endtask

    // hold a target for a run of frames, now and then jump; frame times mostly near 1/30 s
    task automatic run_random_frames(int count);
        logic [TGT_W-1:0] tgt;
        logic [FT_W-1:0]  ft;
        tgt = TGT_W'($urandom_range(0, NUM_SLIDES - 1));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) tgt = TGT_W'($urandom_range(0, (1 << TGT_W) - 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: ft = FT_W'($urandom_range(1000, FRAME_MAX));
                6, 7:             ft = FT_W'($urandom_range(0, (1 << FT_W) - 1));
                8:                ft = FT_W'($urandom_range(0, 100));
                default:          ft = FT_W'(FRAME_MAX + $urandom_range(0, 1));
            endcase
            send_frame(tgt, ft);
        end
    endtask

    task automatic finish_phase();
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        tracker = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_GAIN_P;
        i_cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.target_index <= '0;
        in_if.frame_time <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_limits(GAIN_P_RST, SPEED_LIMIT_RST, ACCEL_LIMIT_RST, APPROACH_GAIN_RST);
        run_frames(0, 0, 1);
        run_frames(63, FRAME_MAX, 4);
        run_frames(63, 16'hFFFF, 2);
        run_frames(63, FRAME_MAX + 1, 1);
        run_frames(0, 1, 1);
        run_frames(0, FRAME_MAX, 3);
        run_frames(5, FRAME_MAX, 4);
        finish_phase();

        // zero gain leaves the boost alone, never negated
        apply_limits(0, SPEED_LIMIT_RST, ACCEL_LIMIT_RST, APPROACH_TOP);
        run_frames(10, FRAME_MAX, 3);
        finish_phase();

        // build up speed, then drop the limit and let the clamp pull it down
        apply_limits(16'hFFFF, 21'h1FFFFF, 16'hFFFF, APPROACH_GAIN_RST);
        run_frames(63, FRAME_MAX, 3);
        finish_phase();
        apply_limits(GAIN_P_RST, 65536, ACCEL_LIMIT_RST, APPROACH_GAIN_RST);
        run_frames(63, FRAME_MAX, 2);
        finish_phase();

        for (int p = 0; p < 8; p++) begin
            if (p == 0)
                apply_limits(0, 0, 0, 0);
            else if (p == 1)
                apply_limits(16'hFFFF, 21'h1FFFFF, 16'hFFFF, 15'h7FFF);
            else if (p == 2)
                apply_limits(GAIN_P_TOP, SPEED_TOP, ACCEL_TOP, APPROACH_TOP);
            else
                apply_limits(pick_setting(GAIN_P_TOP, GAIN_W), pick_setting(SPEED_TOP, VLIM_W),
                             pick_setting(ACCEL_TOP, ALIM_W),
                             pick_setting(APPROACH_TOP, AGAIN_W));
            calm = (p == 7);
            run_random_frames(75);
            finish_phase();
        end

        repeat (100) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
